/* src/triangle_edge_rasterizer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Triangle edge rasterizer assertion macros
// Shared wrappers for concurrent assertions, clocked on a rising edge and
// switched off while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_RASTERIZER_UNIT_MACROS_SVH
`define TRIANGLE_EDGE_RASTERIZER_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define TRIRAST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define TRIRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/trirast_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle edge rasterizer package
// Field widths, register codes, reset values and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package trirast_pkg;

	localparam int COORD_BITS_DEF    = 12;
	localparam int MAX_FRAME_DIM_DEF = 4096;

	localparam int DIM_BITS      = 13;
	localparam int BPP_BITS      = 3;
	localparam int PIX_BITS      = 12;
	localparam int ADDR_BITS     = 26;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [BPP_BITS-1:0] BPP_RST          = 3'd4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH     = 2'd0,
		REG_FRAME_HEIGHT    = 2'd1,
		REG_BYTES_PER_PIXEL = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	// Control that travels with a pixel down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

	// Frame dimensions above the supported maximum are taken as the maximum.
	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d,
			input int unsigned lim);
		if (32'(d) > lim) begin
			return DIM_BITS'(lim);
		end
		return d;
	endfunction

endpackage

`default_nettype wire

/* src/trirast_scan.sv */
// ----------------------------------------------------------------------------
// Triangle scan front end
// Holds the loaded triangle and its clipped bounding box, walks the box in
// row-major order and registers each pixel with its edge operand deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module trirast_scan #(
	parameter int COORD_BITS = trirast_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic signed [COORD_BITS-1:0]       vert_x [3],
	input  logic signed [COORD_BITS-1:0]       vert_y [3],
	input  logic [trirast_pkg::DIM_BITS-1:0]   frame_w,
	input  logic [trirast_pkg::DIM_BITS-1:0]   frame_h,
	input  logic                               next_ready,
	output trirast_pkg::stage_ctl_t            ctl_s1,
	output logic [COORD_BITS-2:0]              px_s1,
	output logic [COORD_BITS-2:0]              py_s1,
	output logic signed [COORD_BITS:0]         dx_s1 [3],
	output logic signed [COORD_BITS:0]         dy_s1 [3],
	output logic signed [COORD_BITS:0]         qx_s1 [3],
	output logic signed [COORD_BITS:0]         qy_s1 [3]
);
	import trirast_pkg::*;

	localparam int XW = COORD_BITS - 1;
	localparam int DW = COORD_BITS + 1;
	localparam int CW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

	logic signed [COORD_BITS-1:0] vx_q [3];
	logic signed [COORD_BITS-1:0] vy_q [3];
	logic [XW-1:0] min_x_q, min_y_q, end_x_q, end_y_q;
	logic [XW-1:0] scan_x_q, scan_y_q;
	logic          scan_active_q;

	logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [CW-1:0] hi_x_ext, hi_y_ext, w_ext, h_ext, end_x_full, end_y_full;
	logic signed [CW-1:0] min_x_ext, min_y_ext;
	logic [XW-1:0] min_x_c, min_y_c;
	logic          active_c;
	logic [XW:0]   inc_x, inc_y;
	logic          last_x, last_y, last_c;
	logic          ready, accept, is_load, emit;
	logic signed [DW-1:0] dx_c [3], dy_c [3], qx_c [3], qy_c [3];

	assign ready    = !ctl_s1.valid || next_ready;
	assign in_stall = !ready;
	assign accept   = in_valid && ready;
	assign is_load  = (command == CMD_LOAD);
	assign emit     = accept && !is_load && scan_active_q;

	// Bounding box of the incoming vertices, clipped to the frame.
	always_comb begin
		lo_x = vert_x[0];
		hi_x = vert_x[0];
		lo_y = vert_y[0];
		hi_y = vert_y[0];
		for (int i = 1; i < 3; i++) begin
			if (vert_x[i] < lo_x) lo_x = vert_x[i];
			if (vert_x[i] > hi_x) hi_x = vert_x[i];
			if (vert_y[i] < lo_y) lo_y = vert_y[i];
			if (vert_y[i] > hi_y) hi_y = vert_y[i];
		end
		min_x_c    = lo_x[COORD_BITS-1] ? '0 : lo_x[XW-1:0];
		min_y_c    = lo_y[COORD_BITS-1] ? '0 : lo_y[XW-1:0];
		hi_x_ext   = $signed({{(CW-COORD_BITS){hi_x[COORD_BITS-1]}}, hi_x});
		hi_y_ext   = $signed({{(CW-COORD_BITS){hi_y[COORD_BITS-1]}}, hi_y});
		w_ext      = $signed({{(CW-DIM_BITS){1'b0}}, frame_w});
		h_ext      = $signed({{(CW-DIM_BITS){1'b0}}, frame_h});
		end_x_full = (hi_x_ext > w_ext) ? w_ext : hi_x_ext;
		end_y_full = (hi_y_ext > h_ext) ? h_ext : hi_y_ext;
		min_x_ext  = $signed({{(CW-XW){1'b0}}, min_x_c});
		min_y_ext  = $signed({{(CW-XW){1'b0}}, min_y_c});
		active_c   = (min_x_ext < end_x_full) && (min_y_ext < end_y_full);
	end

	always_comb begin
		inc_x  = {1'b0, scan_x_q} + 1'b1;
		inc_y  = {1'b0, scan_y_q} + 1'b1;
		last_x = (inc_x >= {1'b0, end_x_q});
		last_y = (inc_y >= {1'b0, end_y_q});
		last_c = last_x && last_y;
	end

	// Edge i runs from vertex i to the next vertex round the triangle.
	always_comb begin
		logic [1:0] nxt;
		for (int i = 0; i < 3; i++) begin
			nxt     = (i == 2) ? 2'd0 : 2'(i + 1);
			dx_c[i] = $signed({vx_q[nxt][COORD_BITS-1], vx_q[nxt]})
				- $signed({vx_q[i][COORD_BITS-1], vx_q[i]});
			dy_c[i] = $signed({vy_q[nxt][COORD_BITS-1], vy_q[nxt]})
				- $signed({vy_q[i][COORD_BITS-1], vy_q[i]});
			qx_c[i] = $signed({2'b00, scan_x_q}) - $signed({vx_q[i][COORD_BITS-1], vx_q[i]});
			qy_c[i] = $signed({2'b00, scan_y_q}) - $signed({vy_q[i][COORD_BITS-1], vy_q[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q <= 1'b0;
			ctl_s1        <= '0;
		end else begin
			if (accept && is_load) begin
				scan_active_q <= active_c;
			end else if (emit && last_c) begin
				scan_active_q <= 1'b0;
			end
			if (ready) begin
				ctl_s1.valid <= emit;
				ctl_s1.last  <= last_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			vx_q     <= vert_x;
			vy_q     <= vert_y;
			min_x_q  <= min_x_c;
			min_y_q  <= min_y_c;
			end_x_q  <= end_x_full[XW-1:0];
			end_y_q  <= end_y_full[XW-1:0];
			scan_x_q <= min_x_c;
			scan_y_q <= min_y_c;
		end else if (emit) begin
			if (last_x) begin
				scan_x_q <= min_x_q;
				scan_y_q <= inc_y[XW-1:0];
			end else begin
				scan_x_q <= inc_x[XW-1:0];
			end
		end
		if (ready && emit) begin
			px_s1 <= scan_x_q;
			py_s1 <= scan_y_q;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			qx_s1 <= qx_c;
			qy_s1 <= qy_c;
		end
	end

endmodule

`default_nettype wire

/* src/trirast_mul.sv */
// ----------------------------------------------------------------------------
// Triangle edge product stage
// Forms the two cross product terms of each edge and the row offset of the
// pixel in the frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module trirast_mul #(
	parameter int COORD_BITS = trirast_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  trirast_pkg::stage_ctl_t               ctl_s1,
	input  logic [COORD_BITS-2:0]                 px_s1,
	input  logic [COORD_BITS-2:0]                 py_s1,
	input  logic signed [COORD_BITS:0]            dx_s1 [3],
	input  logic signed [COORD_BITS:0]            dy_s1 [3],
	input  logic signed [COORD_BITS:0]            qx_s1 [3],
	input  logic signed [COORD_BITS:0]            qy_s1 [3],
	input  logic [trirast_pkg::DIM_BITS-1:0]      pitch,
	input  logic                                  next_ready,
	output logic                                  ready,
	output trirast_pkg::stage_ctl_t               ctl_s2,
	output logic [COORD_BITS-2:0]                 px_s2,
	output logic [COORD_BITS-2:0]                 py_s2,
	output logic signed [2*COORD_BITS+1:0]        pa_s2 [3],
	output logic signed [2*COORD_BITS+1:0]        pb_s2 [3],
	output logic [trirast_pkg::ADDR_BITS-1:0]     row_s2
);
	import trirast_pkg::*;

	localparam int XW = COORD_BITS - 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int RW = XW + DIM_BITS;

	logic signed [PW-1:0] pa_c [3], pb_c [3];
	logic [RW-1:0]        row_full;

	assign ready = !ctl_s2.valid || next_ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa_c[i] = PW'(dx_s1[i]) * PW'(qy_s1[i]);
			pb_c[i] = PW'(dy_s1[i]) * PW'(qx_s1[i]);
		end
		row_full = {{DIM_BITS{1'b0}}, py_s1} * {{XW{1'b0}}, pitch};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (ready) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && ctl_s1.valid) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			pa_s2  <= pa_c;
			pb_s2  <= pb_c;
			row_s2 <= ADDR_BITS'(row_full);
		end
	end

endmodule

`default_nettype wire

/* src/trirast_out.sv */
// ----------------------------------------------------------------------------
// Triangle coverage and address stage
// Resolves the edge signs into coverage, finishes the byte address and holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trirast_out #(
	parameter int COORD_BITS = trirast_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  trirast_pkg::stage_ctl_t               ctl_s2,
	input  logic [COORD_BITS-2:0]                 px_s2,
	input  logic [COORD_BITS-2:0]                 py_s2,
	input  logic signed [2*COORD_BITS+1:0]        pa_s2 [3],
	input  logic signed [2*COORD_BITS+1:0]        pb_s2 [3],
	input  logic [trirast_pkg::ADDR_BITS-1:0]     row_s2,
	input  logic [trirast_pkg::BPP_BITS-1:0]      bpp,
	output logic                                  ready,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [trirast_pkg::PIX_BITS-1:0]      pixel_x,
	output logic [trirast_pkg::PIX_BITS-1:0]      pixel_y,
	output logic                                  covered,
	output logic [trirast_pkg::ADDR_BITS-1:0]     byte_address,
	output logic                                  last_pixel
);
	import trirast_pkg::*;

	localparam int PW = 2 * COORD_BITS + 2;
	localparam int EW = PW + 1;

	logic signed [EW-1:0] edge_c [3];
	logic [2:0]           non_neg, non_pos;
	logic                 cov_c;
	logic [ADDR_BITS-1:0] addr_sum, addr_c;

	assign ready = !out_valid || !out_stall;

	// A pixel is inside when all edges of the triangle agree in sign; zero counts as both.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			edge_c[i]  = $signed({pa_s2[i][PW-1], pa_s2[i]}) - $signed({pb_s2[i][PW-1], pb_s2[i]});
			non_neg[i] = !edge_c[i][EW-1];
			non_pos[i] = edge_c[i][EW-1] || (edge_c[i] == '0);
		end
		cov_c    = (&non_neg) || (&non_pos);
		addr_sum = row_s2 + ADDR_BITS'(px_s2);
		addr_c   = ADDR_BITS'(addr_sum * ADDR_BITS'(bpp));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready) begin
			out_valid <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && ctl_s2.valid) begin
			pixel_x      <= PIX_BITS'(px_s2);
			pixel_y      <= PIX_BITS'(py_s2);
			covered      <= cov_c;
			byte_address <= addr_c;
			last_pixel   <= ctl_s2.last;
		end
	end

endmodule

`default_nettype wire

/* src/triangle_edge_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// Triangle edge rasterizer
// Scans the clipped bounding box of a loaded triangle one pixel per step and
// reports coverage and frame buffer byte address for each pixel.
// ----------------------------------------------------------------------------
// A step transfer passes the scan, edge product and output registers in that
// order. One item is taken per clock while the input is not stalled; the input
// stalls only when all three registers hold pixels and the output is stalled.
// Loads and idle steps give no result.
// Reset clears the pipeline, leaves no triangle loaded and sets the frame to
// 640 by 480 at four bytes per pixel.
`default_nettype none

module triangle_edge_rasterizer_unit #(
	parameter int          COORD_BITS    = trirast_pkg::COORD_BITS_DEF,
	parameter int unsigned MAX_FRAME_DIM = trirast_pkg::MAX_FRAME_DIM_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [trirast_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [trirast_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   command,
	input  logic signed [COORD_BITS-1:0]           vert0_x,
	input  logic signed [COORD_BITS-1:0]           vert0_y,
	input  logic signed [COORD_BITS-1:0]           vert1_x,
	input  logic signed [COORD_BITS-1:0]           vert1_y,
	input  logic signed [COORD_BITS-1:0]           vert2_x,
	input  logic signed [COORD_BITS-1:0]           vert2_y,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [trirast_pkg::PIX_BITS-1:0]       pixel_x,
	output logic [trirast_pkg::PIX_BITS-1:0]       pixel_y,
	output logic                                   covered,
	output logic [trirast_pkg::ADDR_BITS-1:0]      byte_address,
	output logic                                   last_pixel
);
	import trirast_pkg::*;

	localparam int XW = COORD_BITS - 1;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;

	logic [DIM_BITS-1:0] frame_width_q, frame_height_q;
	logic [BPP_BITS-1:0] bpp_q;
	logic [DIM_BITS-1:0] width_eff, height_eff;

	logic signed [COORD_BITS-1:0] vert_x [3], vert_y [3];
	stage_ctl_t           ctl_s1, ctl_s2;
	logic [XW-1:0]        px_s1, py_s1, px_s2, py_s2;
	logic signed [DW-1:0] dx_s1 [3], dy_s1 [3], qx_s1 [3], qy_s1 [3];
	logic signed [PW-1:0] pa_s2 [3], pb_s2 [3];
	logic [ADDR_BITS-1:0] row_s2;
	logic                 ready_s2, ready_out;

	assign cfg_ready  = 1'b1;
	assign width_eff  = clamp_dim(frame_width_q, MAX_FRAME_DIM);
	assign height_eff = clamp_dim(frame_height_q, MAX_FRAME_DIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			bpp_q          <= BPP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:     frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT:    frame_height_q <= cfg_data;
				REG_BYTES_PER_PIXEL: bpp_q          <= cfg_data[BPP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign vert_x[0] = vert0_x;
	assign vert_x[1] = vert1_x;
	assign vert_x[2] = vert2_x;
	assign vert_y[0] = vert0_y;
	assign vert_y[1] = vert1_y;
	assign vert_y[2] = vert2_y;

	trirast_scan #(.COORD_BITS(COORD_BITS)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.vert_x     (vert_x),
		.vert_y     (vert_y),
		.frame_w    (width_eff),
		.frame_h    (height_eff),
		.next_ready (ready_s2),
		.ctl_s1     (ctl_s1),
		.px_s1      (px_s1),
		.py_s1      (py_s1),
		.dx_s1      (dx_s1),
		.dy_s1      (dy_s1),
		.qx_s1      (qx_s1),
		.qy_s1      (qy_s1)
	);

	trirast_mul #(.COORD_BITS(COORD_BITS)) u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.px_s1      (px_s1),
		.py_s1      (py_s1),
		.dx_s1      (dx_s1),
		.dy_s1      (dy_s1),
		.qx_s1      (qx_s1),
		.qy_s1      (qy_s1),
		.pitch      (width_eff),
		.next_ready (ready_out),
		.ready      (ready_s2),
		.ctl_s2     (ctl_s2),
		.px_s2      (px_s2),
		.py_s2      (py_s2),
		.pa_s2      (pa_s2),
		.pb_s2      (pb_s2),
		.row_s2     (row_s2)
	);

	trirast_out #(.COORD_BITS(COORD_BITS)) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s2       (ctl_s2),
		.px_s2        (px_s2),
		.py_s2        (py_s2),
		.pa_s2        (pa_s2),
		.pb_s2        (pb_s2),
		.row_s2       (row_s2),
		.bpp          (bpp_q),
		.ready        (ready_out),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.covered      (covered),
		.byte_address (byte_address),
		.last_pixel   (last_pixel)
	);

endmodule

`default_nettype wire

/* src/trirast_chk.sv */
// ----------------------------------------------------------------------------
// Triangle edge rasterizer port checker
// Watches the ports of the rasterizer for pipeline and output behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_edge_rasterizer_unit_macros.svh"

module trirast_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                command,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [trirast_pkg::PIX_BITS-1:0]    pixel_x,
	input logic [trirast_pkg::PIX_BITS-1:0]    pixel_y,
	input logic [trirast_pkg::ADDR_BITS-1:0]   byte_address
);
	import trirast_pkg::*;

	logic seen_load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_load_q <= 1'b0;
		end else if (in_valid && !in_stall && (command == CMD_LOAD)) begin
			seen_load_q <= 1'b1;
		end
	end

	// With the output register empty every stage behind it can move.
	`TRIRAST_ASSERT_SAME(a_empty_out_no_stall, clk, arst_n, !out_valid, !in_stall,
		"input stalled while the output register is empty")

	// No pixel can appear before a triangle has been loaded.
	`TRIRAST_ASSERT_SAME(a_no_pixel_before_load, clk, arst_n, !seen_load_q, !out_valid,
		"result shown before any triangle load")

	`TRIRAST_ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(byte_address),
		"stalled result changed or was dropped")

endmodule

bind triangle_edge_rasterizer_unit trirast_chk u_trirast_chk (.*);

`default_nettype wire
